// ===== src/rre_pkg.sv =====
// ----------------------------------------------------------------------------
// rre_pkg: shared types and constants of the row RMS engine
// Field widths, iteration counts and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rre_pkg;

  localparam int SAMPLE_W   = 16;             // signed Q8.8 input sample
  localparam int MAG_W      = SAMPLE_W + 1;   // magnitude, holds 2^15
  localparam int SQ_W       = 31;             // square is at most 2^30
  localparam int SUM_W      = 38;             // running sum of squares
  localparam int DIV_W      = 9;              // mean divisor register
  localparam int RMS_W      = 20;             // Q12.8 unsigned result
  localparam int ROOT_STEPS = SUM_W / 2;      // one root bit per step
  localparam int ROOT_W     = ROOT_STEPS;     // root of a SUM_W-bit value
  localparam int RREM_W     = ROOT_W + 2;     // partial remainder of the root
  localparam int CNT_W      = $clog2(SUM_W);  // step counter

  typedef struct packed {
    logic capture;     // take an input sample and square it
    logic accumulate;  // add the square into the running sum
    logic div_step;    // one quotient bit of the mean
    logic root_step;   // one bit of the square root
    logic load_out;    // move the root into the output register
  } rre_cmd_t;

  typedef struct packed {
    logic row_end;     // the captured sample closes its row
    logic div_last;    // this is the final divide step
    logic root_last;   // this is the final root step
    logic out_full;    // output register holds an untaken result
  } rre_status_t;

endpackage

// ===== src/rre_ctrl.sv =====
// ----------------------------------------------------------------------------
// rre_ctrl: sequencing controller of the row RMS engine
// Walks each sample through squaring and accumulation, and at a row end
// through the iterative divide, the iterative root and the output load.
// ----------------------------------------------------------------------------
module rre_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rre_pkg::rre_status_t status,
  output rre_pkg::rre_cmd_t    cmd
);
  import rre_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ACC  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_ROOT = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.accumulate = 1'b1;
        state_next     = status.row_end ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait until the previous result has been taken.
        if (!status.out_full) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/rre_datapath.sv =====
// ----------------------------------------------------------------------------
// rre_datapath: arithmetic and storage of the row RMS engine
// Squarer, saturating accumulator, bit-serial divider, bit-serial square
// root, the divisor register and the output register.
// ----------------------------------------------------------------------------
module rre_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  rre_pkg::rre_cmd_t                   cmd,
  output rre_pkg::rre_status_t                status,
  input  logic signed [rre_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last_in_row,
  input  logic                                cfg_write_en,
  input  logic [rre_pkg::DIV_W-1:0]           cfg_write_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [rre_pkg::RMS_W-1:0]           rms_value,
  output logic                                sum_saturated
);
  import rre_pkg::*;

  logic [DIV_W-1:0]    mean_divisor;
  logic [SUM_W-1:0]    sum;
  logic                sat;
  logic [SQ_W-1:0]     sq;
  logic                last_q;
  logic                row_sat;
  logic [SUM_W-1:0]    quot;
  logic [DIV_W-1:0]    div_rem;
  logic [RREM_W-1:0]   root_rem;
  logic [ROOT_W-1:0]   root;
  logic [CNT_W-1:0]    step_cnt;

  logic [MAG_W-1:0]    ext;
  logic [MAG_W-1:0]    mag;
  logic [2*MAG_W-1:0]  prod;
  logic [SUM_W:0]      sum_wide;
  logic                sat_hit;
  logic [SUM_W-1:0]    sum_add;
  logic                sat_next;
  logic [DIV_W-1:0]    div_eff;
  logic [DIV_W:0]      div_shift;
  logic                div_ge;
  logic [DIV_W-1:0]    div_rem_next;
  logic [RREM_W+1:0]   root_shift;
  logic [RREM_W+1:0]   root_trial;
  logic                root_ge;
  logic [RREM_W-1:0]   root_rem_next;
  logic                div_last;
  logic                root_last;

  // Magnitude of the sample; the most negative code maps to 2^15.
  assign ext  = {sample[SAMPLE_W-1], sample};
  assign mag  = sample[SAMPLE_W-1] ? (~ext + MAG_W'(1)) : ext;
  assign prod = (2*MAG_W)'(mag) * (2*MAG_W)'(mag);

  // Saturating accumulation at the all-ones ceiling.
  assign sum_wide = {1'b0, sum} + (SUM_W+1)'(sq);
  assign sat_hit  = sum_wide[SUM_W] | (&sum_wide[SUM_W-1:0]);
  assign sum_add  = sat_hit ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  assign sat_next = sat | sat_hit;

  // Restoring division, one quotient bit per step; a zero divisor acts as one.
  assign div_eff      = (mean_divisor == '0) ? DIV_W'(1) : mean_divisor;
  assign div_shift    = {div_rem, quot[SUM_W-1]};
  assign div_ge       = div_shift >= {1'b0, div_eff};
  assign div_rem_next = div_ge ? DIV_W'(div_shift - {1'b0, div_eff})
                               : div_shift[DIV_W-1:0];

  // Digit-by-digit square root, two radicand bits per step.
  assign root_shift    = {root_rem, quot[SUM_W-1:SUM_W-2]};
  assign root_trial    = (RREM_W+2)'({root, 2'b01});
  assign root_ge       = root_shift >= root_trial;
  assign root_rem_next = root_ge ? RREM_W'(root_shift - root_trial)
                                 : root_shift[RREM_W-1:0];

  assign div_last  = step_cnt == CNT_W'(SUM_W - 1);
  assign root_last = step_cnt == CNT_W'(ROOT_STEPS - 1);

  assign status.row_end   = last_q;
  assign status.div_last  = div_last;
  assign status.root_last = root_last;
  assign status.out_full  = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_divisor <= DIV_W'(1);
      sum          <= '0;
      sat          <= 1'b0;
      step_cnt     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        mean_divisor <= cfg_write_data;
      end
      if (cmd.accumulate) begin
        if (last_q) begin
          sum <= '0;
          sat <= 1'b0;
        end else begin
          sum <= sum_add;
          sat <= sat_next;
        end
      end
      if (cmd.accumulate || (cmd.div_step && div_last)) begin
        step_cnt <= '0;
      end else if (cmd.div_step || cmd.root_step) begin
        step_cnt <= step_cnt + CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sq     <= prod[SQ_W-1:0];
      last_q <= last_in_row;
    end
    if (cmd.accumulate) begin
      quot    <= sum_add;
      div_rem <= '0;
      row_sat <= sat_next;
    end
    if (cmd.div_step) begin
      quot    <= {quot[SUM_W-2:0], div_ge};
      div_rem <= div_rem_next;
      if (div_last) begin
        root_rem <= '0;
        root     <= '0;
      end
    end
    if (cmd.root_step) begin
      quot     <= {quot[SUM_W-3:0], 2'b00};
      root_rem <= root_rem_next;
      root     <= {root[ROOT_W-2:0], root_ge};
    end
    if (cmd.load_out) begin
      rms_value     <= RMS_W'(root);
      sum_saturated <= row_sat;
    end
  end

endmodule

// ===== src/row_rms_engine_unit.sv =====
// ----------------------------------------------------------------------------
// row_rms_engine_unit: root mean square of rows of Q8.8 samples
// Squares and accumulates each sample, and at the end of a row divides the
// sum by the configured divisor and emits the Q12.8 square root.
// ----------------------------------------------------------------------------
// A sample without the row-end flag is squared and then added; a row-end sample
// is squared, added, and run through 38 divide steps of the bit-serial divider,
// 19 root steps of the bit-serial root and one output load, which waits until
// the previous result is taken. out_valid is registered and set by that load.
// Reset (rst, synchronous): clears the sum, the flag and the output valid,
// and sets the divisor register to one.
module row_rms_engine_unit (
  input  logic                                clk,
  input  logic                                rst,
  // Divisor register write port.
  input  logic                                cfg_write_en,
  input  logic [rre_pkg::DIV_W-1:0]           cfg_write_data,
  // Sample channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rre_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last_in_row,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rre_pkg::RMS_W-1:0]           rms_value,
  output logic                                sum_saturated
);
  import rre_pkg::*;

  rre_cmd_t    cmd;
  rre_status_t status;

  // The controller only sequences; all arithmetic and storage sit in the
  // datapath. A transfer on the input side is taken only in the idle state,
  // while the output register lets a finished result wait independently.
  rre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rre_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .sample         (sample),
    .last_in_row    (last_in_row),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .rms_value      (rms_value),
    .sum_saturated  (sum_saturated)
  );

  // A result is never loaded over one that has not been transferred.
  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_valid)
    else $error("result loaded over a pending result");

  // A row-end sample blocks further input while its root is computed.
  a_row_end_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last_in_row) |=> in_stall)
    else $error("input taken during row-end processing");

  // The root of a 38-bit mean always fits in 19 bits.
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !rms_value[RMS_W-1])
    else $error("rms value out of range");

  // The controller issues at most one command per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.accumulate, cmd.div_step, cmd.root_step,
              cmd.load_out}))
    else $error("overlapping datapath commands");

  // The block is ready for input right after reset.
  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !in_stall)
    else $error("input stalled after reset");

endmodule
